@@ hdl/double_ended_queue_with_dump_defines.svh @@
// ----------------------------------------------------------------------------
// Double-ended queue with dump - assertion macros
// Shared property wrappers for the queue's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_WITH_DUMP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_WITH_DUMP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define DEQD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque check failed");

// Next-cycle implication, disabled while reset is high
`define DEQD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque check failed");

`endif

@@ hdl/deqd_pkg.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue with dump - package
// Command and status codes, controller state type and the command/status
// bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package deqd_pkg;

   // Command codes on req_cmd
   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [2:0] CMD_POP_BACK   = 3'd3;
   localparam logic [2:0] CMD_DUMP_FWD   = 3'd4;
   localparam logic [2:0] CMD_DUMP_BWD   = 3'd5;

   // Status codes on rsp_status
   localparam logic [1:0] ST_DATA  = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // Controller states, one-hot
   typedef enum logic [2:0] {
      S_IDLE     = 3'b001,
      S_DUMP_FWD = 3'b010,
      S_DUMP_BWD = 3'b100
   } deqd_state_type;

   // Controller to datapath
   typedef struct packed {
      logic push_front;
      logic push_back;
      logic pop_front;
      logic pop_back;
      logic load_fwd;
      logic load_bwd;
      logic step_fwd;
      logic step_bwd;
      logic rpt_full;
      logic rpt_empty;
   } deqd_ctl_type;

   // Datapath to controller
   typedef struct packed {
      logic empty;
      logic full;
      logic dump_last;
   } deqd_stat_type;

endpackage

@@ hdl/deqd_ctrl.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue with dump - controller
// Decodes commands, sequences dumps one entry per cycle and drives busy.
// ----------------------------------------------------------------------------
module deqd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [2:0]              req_cmd,
   input  deqd_pkg::deqd_stat_type stat,
   output deqd_pkg::deqd_ctl_type  ctl,
   output logic                    busy
);
   import deqd_pkg::*;

   deqd_state_type state_ff, state_in;
   logic           accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_PUSH_FRONT: begin
                     if (stat.full) ctl.rpt_full = 1'b1;
                     else           ctl.push_front = 1'b1;
                  end
                  CMD_PUSH_BACK: begin
                     if (stat.full) ctl.rpt_full = 1'b1;
                     else           ctl.push_back = 1'b1;
                  end
                  CMD_POP_FRONT: begin
                     ctl.pop_front = !stat.empty;
                  end
                  CMD_POP_BACK: begin
                     ctl.pop_back = !stat.empty;
                  end
                  CMD_DUMP_FWD: begin
                     if (stat.empty) begin
                        ctl.rpt_empty = 1'b1;
                     end else begin
                        ctl.load_fwd = 1'b1;
                        state_in     = S_DUMP_FWD;
                     end
                  end
                  CMD_DUMP_BWD: begin
                     if (stat.empty) begin
                        ctl.rpt_empty = 1'b1;
                     end else begin
                        ctl.load_bwd = 1'b1;
                        state_in     = S_DUMP_BWD;
                     end
                  end
                  default: begin
                     // unused codes: no effect
                  end
               endcase
            end
         end
         S_DUMP_FWD: begin
            ctl.step_fwd = 1'b1;
            if (stat.dump_last) state_in = S_IDLE;
         end
         S_DUMP_BWD: begin
            ctl.step_bwd = 1'b1;
            if (stat.dump_last) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

@@ hdl/deqd_dpath.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue with dump - datapath
// Ring buffer storage, front pointer and fill count, dump read pointer and
// the registered result stage.
// ----------------------------------------------------------------------------
`include "double_ended_queue_with_dump_defines.svh"

module deqd_dpath #(
   parameter int CAPACITY = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic signed [31:0]      req_value,
   input  deqd_pkg::deqd_ctl_type  ctl,
   output deqd_pkg::deqd_stat_type stat,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_item_value,
   output logic [1:0]              rsp_status,
   output logic                    rsp_last_item
);
   import deqd_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W = IDX_W + 1;

   logic [31:0]      mem_ff [CAPACITY];
   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             valid_ff;
   logic [31:0]      value_ff;
   logic [1:0]       status_ff, status_in;
   logic             last_ff, last_in;

   logic [SUM_W-1:0] tail_sum, back_sum;
   logic [IDX_W-1:0] tail_slot, back_slot, front_dec, front_inc;
   logic [IDX_W-1:0] ptr_inc, ptr_dec;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic             step;

   // Ring arithmetic: sums stay below twice the capacity
   assign tail_sum  = SUM_W'(front_ff) + SUM_W'(count_ff);
   assign back_sum  = tail_sum - SUM_W'(1);
   assign tail_slot = (tail_sum >= SUM_W'(CAPACITY)) ?
                      IDX_W'(tail_sum - SUM_W'(CAPACITY)) : IDX_W'(tail_sum);
   assign back_slot = (back_sum >= SUM_W'(CAPACITY)) ?
                      IDX_W'(back_sum - SUM_W'(CAPACITY)) : IDX_W'(back_sum);
   assign front_dec = (front_ff == '0) ? IDX_W'(CAPACITY - 1) : front_ff - IDX_W'(1);
   assign front_inc = (front_ff == IDX_W'(CAPACITY - 1)) ? '0 : front_ff + IDX_W'(1);
   assign ptr_inc   = (rd_ptr_ff == IDX_W'(CAPACITY - 1)) ? '0 : rd_ptr_ff + IDX_W'(1);
   assign ptr_dec   = (rd_ptr_ff == '0) ? IDX_W'(CAPACITY - 1) : rd_ptr_ff - IDX_W'(1);

   // Status to controller
   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff == CNT_W'(CAPACITY));
   assign stat.dump_last = (left_ff == CNT_W'(1));

   assign step = ctl.step_fwd || ctl.step_bwd;

   // Queue pointers
   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      if (ctl.push_front) begin
         front_in = front_dec;
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.push_back) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.pop_front) begin
         front_in = front_inc;
         count_in = count_ff - CNT_W'(1);
      end else if (ctl.pop_back) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Dump read pointer and remaining count
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      left_in   = left_ff;
      if (ctl.load_fwd) begin
         rd_ptr_in = front_ff;
         left_in   = count_ff;
      end else if (ctl.load_bwd) begin
         rd_ptr_in = back_slot;
         left_in   = count_ff;
      end else if (step) begin
         rd_ptr_in = ctl.step_fwd ? ptr_inc : ptr_dec;
         left_in   = left_ff - CNT_W'(1);
      end
   end

   // Result fields
   always_comb begin
      status_in = ST_DATA;
      last_in   = 1'b1;
      if (ctl.rpt_full)       status_in = ST_FULL;
      else if (ctl.rpt_empty) status_in = ST_EMPTY;
      else                    last_in   = stat.dump_last;
   end

   assign wr_en   = ctl.push_front || ctl.push_back;
   assign wr_addr = ctl.push_front ? front_dec : tail_slot;

   // Entry storage
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= req_value;
   end

   // Registered read, zero outside a dump
   always_ff @(posedge clock) begin
      if (step) value_ff <= mem_ff[rd_ptr_ff];
      else      value_ff <= '0;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
         left_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
         left_ff  <= left_in;
         valid_ff <= step || ctl.rpt_full || ctl.rpt_empty;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_item_value = value_ff;
   assign rsp_status     = status_ff;
   assign rsp_last_item  = last_ff;

   // Checks
   `DEQD_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `DEQD_ASSERT_IMP(a_dump_nonempty, clock, reset, ctl.load_fwd || ctl.load_bwd, count_ff != '0)
   `DEQD_ASSERT_NXT(a_dump_end, clock, reset, step && stat.dump_last, rsp_valid && rsp_last_item)
   `DEQD_ASSERT_NXT(a_push_cnt, clock, reset, wr_en, count_ff == $past(count_ff) + CNT_W'(1))

endmodule

@@ hdl/double_ended_queue_with_dump.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue with dump - top level
// Bounded deque of signed 32-bit values in a ring buffer, with front/back
// push and pop and a streaming dump in either direction.
// ----------------------------------------------------------------------------
//  channel  ports                                   handshake
//  request  req_cmd, req_value                      start high, busy low
//  result   rsp_item_value, rsp_status,             rsp_valid, one cycle,
//           rsp_last_item                           no backpressure
//
//  Push and pop complete without raising busy; a new item may follow every cycle.
//  A full push or an empty dump reports one result the cycle after accept.
//  A dump holds busy until its last entry is read, one read of the ring
//  memory per cycle; each result is registered and follows its read in the cycle after.
//  Synchronous reset empties the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module double_ended_queue_with_dump #(
   parameter int CAPACITY = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_cmd,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_item_value,
   output logic [1:0]         rsp_status,
   output logic               rsp_last_item
);
   import deqd_pkg::*;

   deqd_ctl_type  ctl;
   deqd_stat_type stat;

   // Command sequencer
   deqd_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .stat    (stat),
      .ctl     (ctl),
      .busy    (busy)
   );

   // Storage, pointers and result register
   deqd_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_value      (req_value),
      .ctl            (ctl),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_item_value (rsp_item_value),
      .rsp_status     (rsp_status),
      .rsp_last_item  (rsp_last_item)
   );

endmodule

@@ test/double_ended_queue_with_dump_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Double-ended queue with dump - testbench
// Sends push, pop and dump items through the start/busy port and checks
// every result against a ring-buffer copy of the queue held in a scoreboard.
// Directed items cover the edge cases first. Random bursts then fill,
// drain and mix, with random gaps and pauses that let the results drain.
// ----------------------------------------------------------------------------
module double_ended_queue_with_dump_test;
   import deqd_pkg::*;

   localparam int DEPTH       = 32;
   localparam int ITEM_TARGET = 350;
   localparam int CYCLE_LIMIT = 200000;

   // Codes the block has no meaning for; they must be ignored
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;

   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic signed [31:0] value;
      logic [1:0]         status;
      logic               last;
   } deque_result_type;

   // Queue predictor and result checker
   class deque_scoreboard_type;
      logic signed [31:0] slots [DEPTH];
      int unsigned        head;
      int unsigned        fill;
      deque_result_type   awaited [$];
      int                 errors;

      function new();
         head   = 0;
         fill   = 0;
         errors = 0;
      endfunction

      task report(input string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      // Update the queue copy for one accepted item, queue its results
      function void note_item(input logic [2:0] cmd, input logic signed [31:0] value);
         int unsigned off;
         case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
               if (fill >= DEPTH) begin
                  awaited.push_back('{value: 32'sd0, status: ST_FULL, last: 1'b1});
               end else begin
                  if (cmd == CMD_PUSH_FRONT) begin
                     head = (head + DEPTH - 1) % DEPTH;
                     slots[head] = value;
                  end else begin
                     slots[(head + fill) % DEPTH] = value;
                  end
                  fill++;
               end
            end
            CMD_POP_FRONT: begin
               if (fill != 0) begin
                  head = (head + 1) % DEPTH;
                  fill--;
               end
            end
            CMD_POP_BACK: begin
               if (fill != 0) fill--;
            end
            CMD_DUMP_FWD, CMD_DUMP_BWD: begin
               if (fill == 0) begin
                  awaited.push_back('{value: 32'sd0, status: ST_EMPTY, last: 1'b1});
               end else begin
                  for (int unsigned i = 0; i < fill; i++) begin
                     off = (cmd == CMD_DUMP_FWD) ? i : fill - 1 - i;
                     awaited.push_back('{value: slots[(head + off) % DEPTH],
                                         status: ST_DATA, last: (i + 1 == fill)});
                  end
               end
            end
            default: ;
         endcase
      endfunction

      // Compare one result with the oldest expectation
      task check_result(input logic signed [31:0] value, input logic [1:0] status,
                        input logic last);
         deque_result_type want;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected result value %0d status %0d last %0b",
                             value, status, last));
         end else begin
            want = awaited.pop_front();
            if (value !== want.value)
               report($sformatf("item_value %0d, wanted %0d", value, want.value));
            if (status !== want.status)
               report($sformatf("status %0d, wanted %0d", status, want.status));
            if (last !== want.last)
               report($sformatf("last_item %0b, wanted %0b", last, want.last));
         end
      endtask
   endclass

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               start     = 1'b0;
   logic [2:0]         req_cmd   = 3'd0;
   logic signed [31:0] req_value = 32'sd0;
   logic               busy;
   logic               rsp_valid;
   logic signed [31:0] rsp_item_value;
   logic [1:0]         rsp_status;
   logic               rsp_last_item;

   deque_scoreboard_type sb = new();
   int  items_sent = 0;
   int  cycles     = 0;
   bit  steady     = 1'b0;

   double_ended_queue_with_dump #(.CAPACITY(DEPTH)) DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_item_value (rsp_item_value),
      .rsp_status     (rsp_status),
      .rsp_last_item  (rsp_last_item)
   );

   always #1 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Results are sampled at the edge that ends their cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_item_value, rsp_status, rsp_last_item);
   end

   // Present one item, hold it until accepted, then idle a random while unless steady
   task automatic send_item(input logic [2:0] cmd, input logic signed [31:0] value);
      int gap;
      start     <= 1'b1;
      req_cmd   <= cmd;
      req_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_item(cmd, value);
      if (cmd <= CMD_DUMP_BWD) items_sent++;
      gap = steady ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off the sender until every expected result has come
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (sb.awaited.size() != 0) @(posedge clock);
   endtask

   // Extremes turn up often, the rest is uniform
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2:       return 32'sd0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int          burst;
      int unsigned r;
      logic [2:0]  cmd;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty queue, extremes, both ends, spare codes, emptying again
      steady = 1'b0;
      send_item(CMD_DUMP_FWD, 32'sd5);
      send_item(CMD_DUMP_BWD, -32'sd5);
      send_item(CMD_POP_FRONT, 32'sd0);
      send_item(CMD_POP_BACK, 32'sd0);
      send_item(CMD_PUSH_FRONT, VAL_MAX);
      send_item(CMD_PUSH_BACK, VAL_MIN);
      send_item(CMD_PUSH_FRONT, 32'sd0);
      send_item(CMD_PUSH_BACK, -32'sd1);
      send_item(CMD_PUSH_FRONT, 32'sh5555_5555);
      send_item(CMD_PUSH_BACK, 32'shAAAA_AAAA);
      send_item(CMD_DUMP_FWD, 32'sd0);
      send_item(CMD_DUMP_BWD, 32'sd0);
      send_item(CMD_SPARE_6, VAL_MAX);
      send_item(CMD_SPARE_7, VAL_MIN);
      send_item(CMD_POP_FRONT, 32'sd0);
      send_item(CMD_POP_BACK, 32'sd0);
      send_item(CMD_DUMP_FWD, 32'sd0);
      send_item(CMD_POP_FRONT, 32'sd0);
      send_item(CMD_POP_BACK, 32'sd0);
      send_item(CMD_POP_FRONT, 32'sd0);
      send_item(CMD_POP_BACK, 32'sd0);
      send_item(CMD_POP_FRONT, 32'sd0);
      send_item(CMD_DUMP_BWD, 32'sd0);
      drain_results();

      // Random bursts: fill past capacity, drain past empty, mixed, dumps
      while (items_sent < ITEM_TARGET) begin
         steady = ($urandom_range(0, 2) == 0);
         burst  = $urandom_range(0, 4);
         case (burst)
            0: begin
               repeat ($urandom_range(1, 40))
                  send_item($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
                            pick_value());
            end
            1: begin
               repeat ($urandom_range(1, 40))
                  send_item($urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT,
                            pick_value());
            end
            2, 3: begin
               repeat ($urandom_range(1, 20)) begin
                  r = $urandom_range(0, 19);
                  if (r < 8)       cmd = (r[0]) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
                  else if (r < 14) cmd = (r[0]) ? CMD_POP_BACK : CMD_POP_FRONT;
                  else if (r < 18) cmd = (r[0]) ? CMD_DUMP_BWD : CMD_DUMP_FWD;
                  else             cmd = (r[0]) ? CMD_SPARE_7 : CMD_SPARE_6;
                  send_item(cmd, pick_value());
               end
            end
            default: begin
               repeat ($urandom_range(1, 3))
                  send_item($urandom_range(0, 1) ? CMD_DUMP_BWD : CMD_DUMP_FWD,
                            pick_value());
            end
         endcase
         if ($urandom_range(0, 7) == 0) drain_results();
      end

      // Wind down: let all results arrive, then wait a little longer for strays
      start <= 1'b0;
      @(posedge clock);
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
